FILE: hdl/tad_pkg.sv
// ---------------------------------------------------------------------------
// tad_pkg: shared definitions for the triangle area bin downsampler
// Widths, register indexes, reset values and the types that pass between
// the downsampler's modules and its channel interfaces.
// ---------------------------------------------------------------------------
package tad_pkg;

   // point coordinate widths
   localparam int TIME_BITS  = 32;
   localparam int VALUE_BITS = 16;

   // series counters and downsampled index
   localparam int COUNT_BITS = 24;
   localparam int INDEX_BITS = 16;

   // doubled triangle area: each product below 2^(TIME_BITS+VALUE_BITS+1),
   // three of them summed stay below 2^(TIME_BITS+VALUE_BITS+3)
   localparam int DIFF_BITS = VALUE_BITS + 1;
   localparam int PROD_BITS = TIME_BITS + 1 + DIFF_BITS;
   localparam int AREA_BITS = TIME_BITS + VALUE_BITS + 3;
   localparam int SUM_BITS  = AREA_BITS + 1;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOTAL_POINTS   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUTPUT_POINTS  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POINTS_PER_BIN = 2'd2;

   localparam logic [COUNT_BITS-1:0] TOTAL_POINTS_RESET   = 24'd3;
   localparam logic [INDEX_BITS-1:0] OUTPUT_POINTS_RESET  = 16'd2;
   localparam logic [COUNT_BITS-1:0] POINTS_PER_BIN_RESET = 24'd1;

   typedef logic        [TIME_BITS-1:0]  time_type;
   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic        [AREA_BITS-1:0]  area_type;
   typedef logic        [COUNT_BITS-1:0] count_type;
   typedef logic        [INDEX_BITS-1:0] index_type;

   // configuration registers as seen by the series logic
   typedef struct packed {
      count_type total_points;
      index_type output_points;
      count_type points_per_bin;
   } cfg_type;

   // one selected point, qualified by emit
   typedef struct packed {
      logic      emit;
      time_type  out_time;
      value_type out_value;
      index_type out_index;
      logic      final_point;
   } result_type;

endpackage

FILE: hdl/tad_if.sv
// ---------------------------------------------------------------------------
// tad_if: channel interfaces of the triangle area bin downsampler
// Request channel carries one input point, response channel one selected
// point; both use a valid/ready handshake.
// ---------------------------------------------------------------------------
interface tad_req_if
   import tad_pkg::*;
();
   logic      valid;
   logic      ready;
   time_type  sample_time;
   value_type sample_value;

   modport source (output valid, output sample_time, output sample_value, input ready);
   modport sink   (input valid, input sample_time, input sample_value, output ready);
   modport monitor (input valid, input ready, input sample_time, input sample_value);
endinterface

interface tad_rsp_if
   import tad_pkg::*;
();
   logic      valid;
   logic      ready;
   time_type  out_time;
   value_type out_value;
   index_type out_index;
   logic      final_point;

   modport source (output valid, output out_time, output out_value, output out_index,
                   output final_point, input ready);
   modport sink   (input valid, input out_time, input out_value, input out_index,
                   input final_point, output ready);
   modport monitor (input valid, input ready, input out_time, input out_value,
                    input out_index, input final_point);
endinterface

FILE: hdl/triangle_area_bin_downsampler.sv
// ---------------------------------------------------------------------------
// triangle_area_bin_downsampler: streaming triangle area downsampler
// Picks, from a series of (time, value) points, the first point, the point
// of largest triangle area in each inner bin, and the last point.
// ---------------------------------------------------------------------------
// Usage:
//   req_if carries one point per transaction (sample_time, sample_value).
//   rsp_if carries one selected point per transaction with its position in
//   the downsampled series (out_index) and final_point on the last one.
//   csr_we/csr_index/csr_wdata set total_points, output_points and
//   points_per_bin; write them only while no point is in flight.
// Timing:
//   A point goes through an input register, then the area unit and bin
//   logic into the response register; a selected point loads it as it
//   leaves the input register, once the response slot is free. The three
//   area multiplies and the bin compare sit in that one stage, so one
//   point is taken every cycle while no response is held back.
// Reset:
//   Configuration registers return to their reset values, both stages empty,
//   and the next point starts a new series.
// Stall:
//   While rsp_if.ready is low and a response is held, a point can still
//   wait in the input register; further points are refused until the
//   response is taken.
// ---------------------------------------------------------------------------
module triangle_area_bin_downsampler
   import tad_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   tad_req_if.sink                   req_if,
   tad_rsp_if.source                 rsp_if,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   count_type  total_points_ff,   total_points_in;
   index_type  output_points_ff,  output_points_in;
   count_type  points_per_bin_ff, points_per_bin_in;
   logic       in_valid_ff,       in_valid_in;
   time_type   in_time_ff,        in_time_in;
   value_type  in_value_ff,       in_value_in;
   logic       out_valid_ff,      out_valid_in;
   result_type out_result_ff,     out_result_in;

   logic       out_free;
   logic       advance;
   logic       req_accept;
   cfg_type    cfg;
   result_type result;

   // configuration register writes
   always_comb begin
      total_points_in   = total_points_ff;
      output_points_in  = output_points_ff;
      points_per_bin_in = points_per_bin_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_POINTS:   total_points_in   = csr_wdata[COUNT_BITS-1:0];
            CSR_OUTPUT_POINTS:  output_points_in  = csr_wdata[INDEX_BITS-1:0];
            CSR_POINTS_PER_BIN: points_per_bin_in = csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.total_points   = total_points_ff;
   assign cfg.output_points  = output_points_ff;
   assign cfg.points_per_bin = points_per_bin_ff;

   // handshake: the input stage moves on whenever the response slot frees up
   assign out_free      = !out_valid_ff || rsp_if.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_if.ready  = !in_valid_ff || out_free;
   assign req_accept    = req_if.valid && req_if.ready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_time_in  = in_time_ff;
      in_value_in = in_value_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_time_in  = req_if.sample_time;
         in_value_in = req_if.sample_value;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   tad_series u_series (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .cfg          (cfg),
      .sample_time  (in_time_ff),
      .sample_value (in_value_ff),
      .result       (result)
   );

   // response register: load a selected point, drop it once taken
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      if (advance && result.emit) begin
         out_valid_in  = 1'b1;
         out_result_in = result;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_points_ff   <= TOTAL_POINTS_RESET;
         output_points_ff  <= OUTPUT_POINTS_RESET;
         points_per_bin_ff <= POINTS_PER_BIN_RESET;
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         total_points_ff   <= total_points_in;
         output_points_ff  <= output_points_in;
         points_per_bin_ff <= points_per_bin_in;
         in_valid_ff       <= in_valid_in;
         out_valid_ff      <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_time_ff    <= in_time_in;
      in_value_ff   <= in_value_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.out_time    = out_result_ff.out_time;
   assign rsp_if.out_value   = out_result_ff.out_value;
   assign rsp_if.out_index   = out_result_ff.out_index;
   assign rsp_if.final_point = out_result_ff.final_point;

endmodule

FILE: hdl/tad_area.sv
// ---------------------------------------------------------------------------
// tad_area: doubled triangle area
// Computes |xa*(yb-yc) + xb*(yc-ya) + xc*(ya-yb)| exactly, with three
// parallel multiplies, one sum and an absolute value.
// ---------------------------------------------------------------------------
module tad_area
   import tad_pkg::*;
(
   input  time_type  xa,
   input  value_type ya,
   input  time_type  xb,
   input  value_type yb,
   input  time_type  xc,
   input  value_type yc,
   output area_type  area
);

   logic signed [DIFF_BITS-1:0] diff_a;
   logic signed [DIFF_BITS-1:0] diff_b;
   logic signed [DIFF_BITS-1:0] diff_c;
   logic signed [PROD_BITS-1:0] prod_a;
   logic signed [PROD_BITS-1:0] prod_b;
   logic signed [PROD_BITS-1:0] prod_c;
   logic signed [SUM_BITS-1:0]  sum;
   logic        [SUM_BITS-1:0]  magnitude;

   // widen the values by one bit so the differences cannot wrap
   assign diff_a = $signed({yb[VALUE_BITS-1], yb}) - $signed({yc[VALUE_BITS-1], yc});
   assign diff_b = $signed({yc[VALUE_BITS-1], yc}) - $signed({ya[VALUE_BITS-1], ya});
   assign diff_c = $signed({ya[VALUE_BITS-1], ya}) - $signed({yb[VALUE_BITS-1], yb});

   // times are unsigned: zero-extend before the signed multiply
   assign prod_a = $signed({1'b0, xa}) * diff_a;
   assign prod_b = $signed({1'b0, xb}) * diff_b;
   assign prod_c = $signed({1'b0, xc}) * diff_c;

   assign sum = SUM_BITS'(prod_a) + SUM_BITS'(prod_b) + SUM_BITS'(prod_c);

   // take the magnitude; it always fits the unsigned area width
   assign magnitude = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
   assign area      = magnitude[AREA_BITS-1:0];

endmodule

FILE: hdl/tad_series.sv
// ---------------------------------------------------------------------------
// tad_series: series and bin tracking
// Holds the two-point window, the point and bin counters and the best point
// of the open bin; decides per point which point, if any, is emitted.
// ---------------------------------------------------------------------------
module tad_series
   import tad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  cfg_type    cfg,
   input  time_type   sample_time,
   input  value_type  sample_value,
   output result_type result
);

   time_type  win_old_time_ff,  win_old_time_in;
   value_type win_old_value_ff, win_old_value_in;
   time_type  win_new_time_ff,  win_new_time_in;
   value_type win_new_value_ff, win_new_value_in;
   count_type points_seen_ff,   points_seen_in;
   count_type bin_position_ff,  bin_position_in;
   index_type bin_number_ff,    bin_number_in;
   area_type  best_area_ff,     best_area_in;
   time_type  best_time_ff,     best_time_in;
   value_type best_value_ff,    best_value_in;

   area_type                area;
   logic                    first_point;
   logic                    scoring;
   logic                    series_end;
   logic                    take_best;
   logic                    bin_closes;
   logic                    bin_emits;
   logic                    single_point;
   logic [COUNT_BITS:0]     seen_sum;
   logic [COUNT_BITS:0]     position_sum;
   logic [INDEX_BITS:0]     bin_limit;
   count_type               points_per_bin_eff;
   index_type               last_index;

   // score the middle point of the window against the incoming point
   tad_area u_area (
      .xa   (win_old_time_ff),
      .ya   (win_old_value_ff),
      .xb   (win_new_time_ff),
      .yb   (win_new_value_ff),
      .xc   (sample_time),
      .yc   (sample_value),
      .area (area)
   );

   // decode the position in the series and in the open bin
   assign first_point        = (points_seen_ff == '0);
   assign scoring            = (points_seen_ff[COUNT_BITS-1:1] != '0);
   assign single_point       = (cfg.total_points <= COUNT_BITS'(1));
   assign seen_sum           = {1'b0, points_seen_ff} + (COUNT_BITS+1)'(1);
   assign series_end         = !first_point && (seen_sum >= {1'b0, cfg.total_points});
   assign points_per_bin_eff = (cfg.points_per_bin == '0) ? COUNT_BITS'(1)
                                                          : cfg.points_per_bin;
   assign position_sum       = {1'b0, bin_position_ff} + (COUNT_BITS+1)'(1);
   assign bin_closes         = scoring && (position_sum >= {1'b0, points_per_bin_eff});
   assign bin_limit          = {1'b0, bin_number_ff} + (INDEX_BITS+1)'(2);
   assign bin_emits          = bin_closes && (bin_number_ff != '0)
                               && (bin_limit <= {1'b0, cfg.output_points});
   assign take_best          = scoring && ((bin_position_ff == '0) || (area > best_area_ff));
   assign last_index         = (cfg.output_points == '0) ? '0
                                                         : cfg.output_points - INDEX_BITS'(1);

   // next state and result for the point in flight
   always_comb begin
      win_old_time_in  = win_old_time_ff;
      win_old_value_in = win_old_value_ff;
      win_new_time_in  = win_new_time_ff;
      win_new_value_in = win_new_value_ff;
      points_seen_in   = points_seen_ff;
      bin_position_in  = bin_position_ff;
      bin_number_in    = bin_number_ff;
      best_area_in     = best_area_ff;
      best_time_in     = best_time_ff;
      best_value_in    = best_value_ff;
      result           = '0;

      if (step) begin
         // shift the window on every point
         win_old_time_in  = win_new_time_ff;
         win_old_value_in = win_new_value_ff;
         win_new_time_in  = sample_time;
         win_new_value_in = sample_value;

         if (first_point) begin
            result.emit        = 1'b1;
            result.out_time    = sample_time;
            result.out_value   = sample_value;
            result.out_index   = '0;
            result.final_point = single_point;
            if (!single_point) begin
               points_seen_in = COUNT_BITS'(1);
            end
         end else begin
            // keep the first maximum of the open bin
            if (take_best) begin
               best_area_in  = area;
               best_time_in  = win_new_time_ff;
               best_value_in = win_new_value_ff;
            end
            if (scoring) begin
               bin_position_in = bin_closes ? '0 : position_sum[COUNT_BITS-1:0];
               if (bin_closes && (bin_number_ff != '1)) begin
                  bin_number_in = bin_number_ff + INDEX_BITS'(1);
               end
            end

            if (series_end) begin
               // last point wins over a closing bin; restart the series
               result.emit        = 1'b1;
               result.out_time    = sample_time;
               result.out_value   = sample_value;
               result.out_index   = last_index;
               result.final_point = 1'b1;
               points_seen_in     = '0;
               bin_position_in    = '0;
               bin_number_in      = '0;
            end else begin
               points_seen_in = seen_sum[COUNT_BITS-1:0];
               if (bin_emits) begin
                  result.emit      = 1'b1;
                  result.out_time  = best_time_in;
                  result.out_value = best_value_in;
                  result.out_index = bin_number_ff;
               end
            end
         end
      end
   end

   // hold the series state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_old_time_ff  <= '0;
         win_old_value_ff <= '0;
         win_new_time_ff  <= '0;
         win_new_value_ff <= '0;
         points_seen_ff   <= '0;
         bin_position_ff  <= '0;
         bin_number_ff    <= '0;
         best_area_ff     <= '0;
         best_time_ff     <= '0;
         best_value_ff    <= '0;
      end else begin
         win_old_time_ff  <= win_old_time_in;
         win_old_value_ff <= win_old_value_in;
         win_new_time_ff  <= win_new_time_in;
         win_new_value_ff <= win_new_value_in;
         points_seen_ff   <= points_seen_in;
         bin_position_ff  <= bin_position_in;
         bin_number_ff    <= bin_number_in;
         best_area_ff     <= best_area_in;
         best_time_ff     <= best_time_in;
         best_value_ff    <= best_value_in;
      end
   end

endmodule

FILE: hdl/tad_checker.sv
// ---------------------------------------------------------------------------
// tad_checker: port-level checks for the downsampler
// Watches the request and response channels of the top level.
// ---------------------------------------------------------------------------
module tad_checker
   import tad_pkg::*;
(
   input logic       clock,
   input logic       reset,
   tad_req_if.sink   req_if,
   tad_rsp_if.source rsp_if
);

   // a held response keeps its payload until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.out_time)
         && $stable(rsp_if.out_value) && $stable(rsp_if.out_index)
         && $stable(rsp_if.final_point))
      else $error("response transaction changed while stalled");

   // reset leaves both stages empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid && req_if.ready)
      else $error("downsampler not empty after reset");

   // a free response slot always lets a request transaction in
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_if.valid || rsp_if.ready) |-> req_if.ready)
      else $error("request refused while response slot is free");

endmodule

bind triangle_area_bin_downsampler tad_checker u_tad_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for triangle_area_bin_downsampler
// Streams point series through the request channel, predicts each selected
// point from an internal model of the bin logic, and compares every
// response field by field. Both channels idle and stall at random; one
// long response hold-off fills the block and stalls its input.
// ---------------------------------------------------------------------------
module tb;
   import tad_pkg::*;

   localparam int PERIOD       = 20;
   localparam int RESET_CYCLES = 7;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 150;
   localparam int RANDOM_ITEMS = 900;
   localparam int LIMIT_TIME   = 10_000_000;
   localparam int PRINT_LIMIT  = 40;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   // one selected point as it should leave the block
   typedef struct {
      time_type  pt_time;
      value_type pt_value;
      index_type pt_index;
      logic      pt_final;
   } point_type;

   logic clock = 1'b0;
   logic reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   tad_req_if req_if ();
   tad_rsp_if rsp_if ();

   triangle_area_bin_downsampler uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(PERIOD / 2) clock = ~clock;

   // model registers and series state
   count_type   cfg_total;
   index_type   cfg_outputs;
   count_type   cfg_per_bin;
   time_type    prev_time [2];
   value_type   prev_value [2];
   count_type   seen_count;
   count_type   bin_fill;
   index_type   bin_idx;
   logic [63:0] top_area;
   time_type    top_time;
   value_type   top_value;

   point_type expected_points [$];
   int        mismatches = 0;

   // idling controls and long hold-off requests
   bit req_idle_on   = 1'b1;
   bit rsp_idle_on   = 1'b1;
   int hold_requests = 0;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
   endtask

   // doubled triangle area, modulo 2^64, then absolute value
   function automatic logic [63:0] doubled_area(input time_type xa, input value_type ya,
                                                input time_type xb, input value_type yb,
                                                input time_type xc, input value_type yc);
      logic [63:0] x0, x1, x2, y0, y1, y2, s;
      x0 = {{(64 - TIME_BITS){1'b0}}, xa};
      x1 = {{(64 - TIME_BITS){1'b0}}, xb};
      x2 = {{(64 - TIME_BITS){1'b0}}, xc};
      y0 = {{(64 - VALUE_BITS){ya[VALUE_BITS-1]}}, ya};
      y1 = {{(64 - VALUE_BITS){yb[VALUE_BITS-1]}}, yb};
      y2 = {{(64 - VALUE_BITS){yc[VALUE_BITS-1]}}, yc};
      s = x0 * (y1 - y2) + x1 * (y2 - y0) + x2 * (y0 - y1);
      if (s[63])
         s = 64'd0 - s;
      return s;
   endfunction

   function automatic void queue_point(input time_type t, input value_type v,
                                       input index_type idx, input logic fin);
      point_type rec;
      rec.pt_time  = t;
      rec.pt_value = v;
      rec.pt_index = idx;
      rec.pt_final = fin;
      expected_points.push_back(rec);
   endfunction

   function automatic void shift_window(input time_type t, input value_type v);
      prev_time[0]  = prev_time[1];
      prev_value[0] = prev_value[1];
      prev_time[1]  = t;
      prev_value[1] = v;
   endfunction

   function automatic void clear_series();
      seen_count = '0;
      bin_fill   = '0;
      bin_idx    = '0;
      top_area   = '0;
      top_time   = '0;
      top_value  = '0;
   endfunction

   // advance the model by one accepted point and queue what it selects
   function automatic void predict_point(input time_type t, input value_type v);
      count_type   p;
      count_type   per_bin;
      index_type   last_pos;
      logic        closes;
      time_type    close_time;
      value_type   close_value;
      index_type   close_idx;
      logic [63:0] area;
      p           = seen_count;
      per_bin     = (cfg_per_bin == 0) ? count_type'(1) : cfg_per_bin;
      last_pos    = (cfg_outputs == 0) ? index_type'(0) : cfg_outputs - 1'b1;
      closes      = 1'b0;
      close_time  = '0;
      close_value = '0;
      close_idx   = '0;

      if (p == 0) begin
         if (cfg_total <= 1) begin
            queue_point(t, v, '0, 1'b1);
            shift_window(t, v);
            clear_series();
            return;
         end
         queue_point(t, v, '0, 1'b0);
      end else if (p >= 2) begin
         // score the middle point of the window, keep the first maximum
         area = doubled_area(prev_time[0], prev_value[0], prev_time[1], prev_value[1], t, v);
         if (bin_fill == 0 || area > top_area) begin
            top_area  = area;
            top_time  = prev_time[1];
            top_value = prev_value[1];
         end
         bin_fill++;
         if (bin_fill >= per_bin) begin
            if (bin_idx >= 1 && int'(bin_idx) + 2 <= int'(cfg_outputs)) begin
               closes      = 1'b1;
               close_time  = top_time;
               close_value = top_value;
               close_idx   = bin_idx;
            end
            if (bin_idx != '1)
               bin_idx++;
            bin_fill = '0;
         end
      end

      shift_window(t, v);

      // last point wins over a bin closing on the same input
      if (p != 0 && int'(p) + 1 >= int'(cfg_total)) begin
         queue_point(t, v, last_pos, 1'b1);
         clear_series();
         return;
      end
      if (closes)
         queue_point(close_time, close_value, close_idx, 1'b0);
      seen_count = p + 1'b1;
   endfunction

   // offer one point; valid stays high if the next point follows at once
   task automatic send_point(input time_type t, input value_type v);
      int gap;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.sample_time  <= t;
      req_if.sample_value <= v;
      do
         @(posedge clock);
      while (!req_if.ready);
      predict_point(t, v);
   endtask

   // drop valid and let every expected response and the pipeline drain
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write one register; end_writes drops the enable afterwards
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_TOTAL_POINTS:   cfg_total   = data[COUNT_BITS-1:0];
         CSR_OUTPUT_POINTS:  cfg_outputs = data[INDEX_BITS-1:0];
         CSR_POINTS_PER_BIN: cfg_per_bin = data[COUNT_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      csr_we <= 1'b0;
   endtask

   task automatic set_series(input int n_total, input int n_out, input int n_per);
      write_reg(CSR_TOTAL_POINTS, CSR_DATA_BITS'(n_total));
      write_reg(CSR_OUTPUT_POINTS, CSR_DATA_BITS'(n_out));
      write_reg(CSR_POINTS_PER_BIN, CSR_DATA_BITS'(n_per));
      end_writes();
   endtask

   // response side: random stalls, plus long hold-offs on request
   initial begin
      int hold_left;
      int stall_left;
      int holds_served;
      hold_left    = 0;
      stall_left   = 0;
      holds_served = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_idle_on && $urandom_range(0, 2) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // compare each response transaction with the oldest expected point
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_points.size() == 0) begin
            report("response with none pending", 64'(rsp_if.out_time), 64'd0);
         end else begin
            want = expected_points.pop_front();
            if (rsp_if.out_time !== want.pt_time)
               report("out_time", 64'(rsp_if.out_time), 64'(want.pt_time));
            if (rsp_if.out_value !== want.pt_value)
               report("out_value", 64'(rsp_if.out_value), 64'(want.pt_value));
            if (rsp_if.out_index !== want.pt_index)
               report("out_index", 64'(rsp_if.out_index), 64'(want.pt_index));
            if (rsp_if.final_point !== want.pt_final)
               report("final_point", 64'(rsp_if.final_point), 64'(want.pt_final));
         end
      end
   end

   // reset values: three points, first and last selected
   task automatic test_reset_values();
      send_point(32'd10, 16'sd100);
      send_point(32'd20, -16'sd50);
      send_point(32'd30, 16'sd7);
   endtask

   // extreme coordinates, zero bin size, inner bin dropped by the last point
   task automatic test_area_extremes();
      wait_idle();
      set_series(5, 4, 0);
      send_point(32'h0000_0000, 16'sh8000);
      send_point(32'hFFFF_FFFF, 16'sh7FFF);
      send_point(32'h0000_0000, 16'sh8000);
      send_point(32'hFFFF_FFFF, 16'sh7FFF);
      send_point(32'h8000_0000, 16'sh0000);
   endtask

   // flat series: every area ties, the first point of the bin must win
   task automatic test_equal_areas();
      wait_idle();
      set_series(7, 3, 2);
      for (int i = 1; i <= 7; i++)
         send_point(time_type'(i * 100), 16'sh0100);
   endtask

   // series of zero, one and two points, zero output count
   task automatic test_short_series();
      wait_idle();
      set_series(0, 2, 1);
      send_point(32'h1234_5678, -16'sd1);
      wait_idle();
      write_reg(CSR_TOTAL_POINTS, 24'd1);
      end_writes();
      send_point(32'h8765_4321, 16'sd1);
      wait_idle();
      write_reg(CSR_TOTAL_POINTS, 24'd2);
      write_reg(CSR_OUTPUT_POINTS, 24'd0);
      end_writes();
      send_point(32'd5, 16'sh7FFF);
      send_point(32'd6, 16'sh8000);
   endtask

   // largest settings, unused index, then total lowered mid-series
   task automatic test_lowered_total();
      wait_idle();
      write_reg(CSR_TOTAL_POINTS, 24'hFF_FFFF);
      write_reg(CSR_OUTPUT_POINTS, 24'h00_FFFF);
      write_reg(CSR_POINTS_PER_BIN, 24'hFF_FFFF);
      write_reg(CSR_UNUSED, 24'h00_0001);
      end_writes();
      send_point(32'd1, 16'sd300);
      send_point(32'd2, -16'sd300);
      send_point(32'd3, 16'sd300);
      wait_idle();
      write_reg(CSR_TOTAL_POINTS, 24'd3);
      end_writes();
      send_point(32'd4, -16'sd300);
   endtask

   // hold responses off while points keep coming, so the input stalls
   task automatic test_backpressure();
      wait_idle();
      set_series(60, 60, 1);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_requests++;
      for (int i = 0; i < 60; i++)
         send_point(time_type'(1000 + i * 7), value_type'($urandom_range(0, 65535)));
      wait_idle();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // random series, mostly well formed, some noise and cut-short series
   task automatic test_random_series();
      int sent;
      int n_total, n_out, n_per, rem, mode, r;
      time_type  t;
      value_type v;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         req_idle_on = ($urandom_range(0, 4) != 0);
         rsp_idle_on = ($urandom_range(0, 4) != 0);

         // keep the settings now and then and stream straight on
         if (!(seen_count == 0 && $urandom_range(0, 3) == 0)) begin
            wait_idle();
            r = $urandom_range(0, 99);
            if (r < 90) begin
               n_total = (r < 5) ? $urandom_range(41, 300) : $urandom_range(3, 40);
               n_out   = $urandom_range(2, (n_total < 12) ? n_total : 12);
               n_per   = (r < 75) ? (n_total - 2) / n_out : $urandom_range(1, 6);
            end else begin
               n_total = $urandom_range(0, 12);
               n_out   = $urandom_range(0, 20);
               n_per   = $urandom_range(0, 5);
            end
            set_series(n_total, n_out, n_per);
         end

         // points left in the open series
         if (seen_count == 0)
            rem = (cfg_total <= 1) ? 1 : int'(cfg_total);
         else if (int'(cfg_total) > int'(seen_count) + 1)
            rem = int'(cfg_total) - int'(seen_count);
         else
            rem = 1;
         if (rem > 400)
            rem = 400;
         if ($urandom_range(0, 9) == 0)
            rem = $urandom_range(1, rem);

         mode = $urandom_range(0, 2);
         t    = $urandom;
         v    = value_type'($urandom_range(0, 65535));
         for (int i = 0; i < rem; i++) begin
            case (mode)
               0: begin
                  t = $urandom;
                  v = value_type'($urandom_range(0, 65535));
               end
               1: begin
                  t = t + $urandom_range(1, 200);
                  v = v + value_type'($urandom_range(0, 512) - 256);
               end
               default: begin
                  t = t + $urandom_range(0, 3);
                  v = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
               end
            endcase
            send_point(t, v);
            sent++;
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.sample_time  <= '0;
      req_if.sample_value <= '0;
      csr_we              <= 1'b0;
      csr_index           <= CSR_TOTAL_POINTS;
      csr_wdata           <= '0;
      cfg_total   = TOTAL_POINTS_RESET;
      cfg_outputs = OUTPUT_POINTS_RESET;
      cfg_per_bin = POINTS_PER_BIN_RESET;
      prev_time   = '{default: '0};
      prev_value  = '{default: '0};
      clear_series();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_area_extremes();
      test_equal_areas();
      test_short_series();
      test_lowered_total();
      test_backpressure();
      test_random_series();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_points.size() != 0)
         report("points never returned", 64'(expected_points.size()), 64'd0);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // hard stop if the run hangs
   initial begin
      #(LIMIT_TIME);
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: triangle_area_bin_downsampler.f
hdl/tad_pkg.sv
hdl/tad_if.sv
hdl/tad_area.sv
hdl/tad_series.sv
hdl/triangle_area_bin_downsampler.sv
hdl/tad_checker.sv
tb/tb.sv
